// File: rtl/lpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types, constants and helpers for the lidar polar-to-Cartesian block.
// ----------------------------------------------------------------------------
package lpc_pkg;

  // Default widths of the range and angle datapaths
  localparam int RANGE_BITS_DEF = 16;
  localparam int ANGLE_BITS_DEF = 16;

  // Register and port widths
  localparam int CFG_W        = 16;
  localparam int APB_AW       = 4;
  localparam int APB_DW       = 32;
  localparam int RANGE_IN_W   = 16;
  localparam int COORD_W      = 17;
  localparam int OUT_TDATA_W  = 40;

  // CORDIC datapath
  localparam int CORDIC_STEPS = 30;
  localparam int PHASE_W      = 32;
  localparam int CX_W         = 33;
  localparam int CZ_W         = 32;
  localparam int TRIG_W       = 18;

  localparam logic signed [CX_W-1:0] CORDIC_GAIN_INV = 33'sd652032874;

  localparam logic signed [CZ_W-1:0] ATAN_TBL [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81,
    32'sd41,        32'sd20,        32'sd10,        32'sd5,
    32'sd3,         32'sd1
  };

  // Rounding and saturation
  localparam int TRIG_ROUND_SH = 14;
  localparam int TRIG_HALF     = 8192;
  localparam int TRIG_LIMIT    = 65536;
  localparam int PROD_ROUND_SH = 16;
  localparam int PROD_HALF     = 32768;
  localparam int COORD_LIMIT   = 65535;

  localparam logic [CFG_W-1:0] MAX_RANGE_RST = 16'hFFFF;

  // Register map, word index
  typedef enum logic [1:0] {
    REG_START_ANGLE = 2'd0,
    REG_ANGLE_STEP  = 2'd1,
    REG_MIN_RANGE   = 2'd2,
    REG_MAX_RANGE   = 2'd3
  } reg_idx_e;

  // Quadrant of the beam angle
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef struct packed {
    logic [CFG_W-1:0] start_angle;
    logic [CFG_W-1:0] angle_step;
    logic [CFG_W-1:0] min_range;
    logic [CFG_W-1:0] max_range;
  } cfg_t;

  // Round a CORDIC component to Q1.16, half away from zero, clamp to +-1.0
  function automatic logic signed [TRIG_W-1:0] trig_round(input logic signed [CX_W-1:0] v);
    logic signed [CX_W:0] ext;
    logic [CX_W:0]        mag;
    logic [CX_W:0]        rnd;
    logic [TRIG_W-1:0]    lim;
    ext = (CX_W+1)'(v);
    mag = v[CX_W-1] ? -ext : ext;
    rnd = (mag + (CX_W+1)'(TRIG_HALF)) >> TRIG_ROUND_SH;
    if (rnd > (CX_W+1)'(TRIG_LIMIT)) begin
      lim = TRIG_W'(TRIG_LIMIT);
    end else begin
      lim = rnd[TRIG_W-1:0];
    end
    return v[CX_W-1] ? -$signed(lim) : $signed(lim);
  endfunction

endpackage

// File: rtl/lidar_polar_to_cartesian.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_polar_to_cartesian
// Turns a stream of lidar range samples into Cartesian points in mm. The
// block accepts one input word per clock while the input is not stalled.
// A sample inside the open range window appears as one point on the
// output after passing the input register, 30 CORDIC stages, trig
// rounding, range multiply and the output register; samples outside the
// window give no word but still advance the beam angle.
// The input stalls only while both the output register and its skid slot are
// full. Set the registers while the stream is idle.
// ----------------------------------------------------------------------------
module lidar_polar_to_cartesian #(
  parameter int RANGE_BITS = lpc_pkg::RANGE_BITS_DEF,
  parameter int ANGLE_BITS = lpc_pkg::ANGLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Sample stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lpc_pkg::RANGE_IN_W-1:0]      s_axis_tdata,  // [15:0] range_sample
  input  logic [0:0]                          s_axis_tuser,  // [0] first_of_scan
  // Point stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lpc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // [16:0] point_x,
                                                             // [33:17] point_y, [39:34] 0
  // Configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lpc_pkg::APB_AW-1:0]          paddr,
  input  logic [lpc_pkg::APB_DW-1:0]          pwdata,
  output logic [lpc_pkg::APB_DW-1:0]          prdata,
  output logic                                pready
);
  import lpc_pkg::*;

  localparam int CMP_W = (RANGE_BITS > CFG_W) ? RANGE_BITS : CFG_W;

  cfg_t                    cfg;
  logic                    pipe_en;
  logic                    s_accept;
  logic [RANGE_BITS-1:0]   range_in;
  logic                    in_window;
  logic [ANGLE_BITS-1:0]   beam_angle_q, beam_angle_d;
  logic [PHASE_W-1:0]      phase;

  logic                    in_valid_q;
  logic [RANGE_BITS-1:0]   in_range_q;
  logic [1:0]              in_quad_q;
  logic [PHASE_W-3:0]      in_z_q;

  logic                    cor_valid;
  logic [RANGE_BITS-1:0]   cor_range;
  logic [1:0]              cor_quad;
  logic signed [CX_W-1:0]  cor_x, cor_y;

  logic                    pt_valid;
  logic signed [COORD_W-1:0] pt_x, pt_y;
  logic [OUT_TDATA_W-1:0]  pt_word;

  assign pready = 1'b1;

  lpc_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  assign s_axis_tready = pipe_en;
  assign s_accept      = s_axis_tvalid & pipe_en;
  assign range_in      = RANGE_BITS'(s_axis_tdata);

  // Open range window
  assign in_window = (CMP_W'(range_in) > CMP_W'(cfg.min_range)) &&
                     (CMP_W'(range_in) < CMP_W'(cfg.max_range));

  // Restart or advance the beam angle
  assign beam_angle_d = s_axis_tuser[0] ? ANGLE_BITS'(cfg.start_angle)
                                        : beam_angle_q + ANGLE_BITS'(cfg.angle_step);
  assign phase = PHASE_W'(beam_angle_d) << (PHASE_W - ANGLE_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_angle_q <= '0;
      in_valid_q   <= 1'b0;
    end else begin
      if (s_accept) begin
        beam_angle_q <= beam_angle_d;
      end
      if (pipe_en) begin
        in_valid_q <= s_accept & in_window;
      end
    end
  end

  // Input register: range, quadrant and first-quadrant phase
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_range_q <= range_in;
      in_quad_q  <= phase[PHASE_W-1 -: 2];
      in_z_q     <= phase[PHASE_W-3:0];
    end
  end

  lpc_cordic #(
    .RANGE_BITS (RANGE_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (in_valid_q),
    .range_i (in_range_q),
    .quad_i  (in_quad_q),
    .z_i     (in_z_q),
    .valid_o (cor_valid),
    .range_o (cor_range),
    .quad_o  (cor_quad),
    .x_o     (cor_x),
    .y_o     (cor_y)
  );

  lpc_scale #(
    .RANGE_BITS (RANGE_BITS)
  ) u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (pipe_en),
    .valid_i   (cor_valid),
    .range_i   (cor_range),
    .quad_i    (cor_quad),
    .x_i       (cor_x),
    .y_i       (cor_y),
    .valid_o   (pt_valid),
    .point_x_o (pt_x),
    .point_y_o (pt_y)
  );

  assign pt_word = {{(OUT_TDATA_W - 2*COORD_W){1'b0}}, pt_y, pt_x};

  lpc_out_skid u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (pt_valid),
    .data_i     (pt_word),
    .en_o       (pipe_en),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata)
  );

endmodule

// File: rtl/lpc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_cfg_regs
// APB register file: start angle, angle step and the range window.
// ----------------------------------------------------------------------------
module lpc_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [lpc_pkg::APB_AW-1:0]  paddr_i,
  input  logic [lpc_pkg::APB_DW-1:0]  pwdata_i,
  output logic [lpc_pkg::APB_DW-1:0]  prdata_o,
  output lpc_pkg::cfg_t               cfg_o
);
  import lpc_pkg::*;

  logic     wr_en;
  reg_idx_e reg_idx;
  cfg_t     cfg_q, cfg_d;

  assign wr_en   = psel_i & penable_i & pwrite_i;
  assign reg_idx = reg_idx_e'(paddr_i[APB_AW-1:2]);

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_START_ANGLE: cfg_d.start_angle = pwdata_i[CFG_W-1:0];
        REG_ANGLE_STEP:  cfg_d.angle_step  = pwdata_i[CFG_W-1:0];
        REG_MIN_RANGE:   cfg_d.min_range   = pwdata_i[CFG_W-1:0];
        REG_MAX_RANGE:   cfg_d.max_range   = pwdata_i[CFG_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_angle <= '0;
      cfg_q.angle_step  <= '0;
      cfg_q.min_range   <= '0;
      cfg_q.max_range   <= MAX_RANGE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_START_ANGLE: prdata_o = APB_DW'(cfg_q.start_angle);
      REG_ANGLE_STEP:  prdata_o = APB_DW'(cfg_q.angle_step);
      REG_MIN_RANGE:   prdata_o = APB_DW'(cfg_q.min_range);
      REG_MAX_RANGE:   prdata_o = APB_DW'(cfg_q.max_range);
      default:         prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/lpc_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_cordic
// Pipelined rotation-mode CORDIC, one micro-rotation per stage, giving
// cosine and sine of the first-quadrant phase scaled by 2^30.
// ----------------------------------------------------------------------------
module lpc_cordic #(
  parameter int RANGE_BITS = lpc_pkg::RANGE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [RANGE_BITS-1:0]             range_i,
  input  logic [1:0]                        quad_i,
  input  logic [lpc_pkg::PHASE_W-3:0]       z_i,
  output logic                              valid_o,
  output logic [RANGE_BITS-1:0]             range_o,
  output logic [1:0]                        quad_o,
  output logic signed [lpc_pkg::CX_W-1:0]   x_o,
  output logic signed [lpc_pkg::CX_W-1:0]   y_o
);
  import lpc_pkg::*;

  logic                   valid_q [CORDIC_STEPS];
  logic [RANGE_BITS-1:0]  range_q [CORDIC_STEPS];
  logic [1:0]             quad_q  [CORDIC_STEPS];
  logic signed [CX_W-1:0] x_q     [CORDIC_STEPS];
  logic signed [CX_W-1:0] y_q     [CORDIC_STEPS];
  logic signed [CZ_W-1:0] z_q     [CORDIC_STEPS];

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_stage
    logic                   v_prev;
    logic [RANGE_BITS-1:0]  r_prev;
    logic [1:0]             q_prev;
    logic signed [CX_W-1:0] x_prev;
    logic signed [CX_W-1:0] y_prev;
    logic signed [CZ_W-1:0] z_prev;
    logic signed [CX_W-1:0] dx;
    logic signed [CX_W-1:0] dy;

    if (g == 0) begin : g_seed
      // Start on the x axis, pre-scaled by the inverse CORDIC gain
      assign v_prev = valid_i;
      assign r_prev = range_i;
      assign q_prev = quad_i;
      assign x_prev = CORDIC_GAIN_INV;
      assign y_prev = '0;
      assign z_prev = $signed(CZ_W'(z_i));
    end else begin : g_chain
      assign v_prev = valid_q[g-1];
      assign r_prev = range_q[g-1];
      assign q_prev = quad_q[g-1];
      assign x_prev = x_q[g-1];
      assign y_prev = y_q[g-1];
      assign z_prev = z_q[g-1];
    end

    // Floor shifts of the cross terms
    assign dx = y_prev >>> g;
    assign dy = x_prev >>> g;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (en_i) begin
        valid_q[g] <= v_prev;
      end
    end

    // Rotate toward zero residual phase
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        range_q[g] <= r_prev;
        quad_q[g]  <= q_prev;
        if (!z_prev[CZ_W-1]) begin
          x_q[g] <= x_prev - dx;
          y_q[g] <= y_prev + dy;
          z_q[g] <= z_prev - ATAN_TBL[g];
        end else begin
          x_q[g] <= x_prev + dx;
          y_q[g] <= y_prev - dy;
          z_q[g] <= z_prev + ATAN_TBL[g];
        end
      end
    end
  end

  assign valid_o = valid_q[CORDIC_STEPS-1];
  assign range_o = range_q[CORDIC_STEPS-1];
  assign quad_o  = quad_q[CORDIC_STEPS-1];
  assign x_o     = x_q[CORDIC_STEPS-1];
  assign y_o     = y_q[CORDIC_STEPS-1];

endmodule

// File: rtl/lpc_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_scale
// Rounds the CORDIC outputs to Q1.16, unfolds the quadrant, multiplies by
// the range and rounds the products to whole millimetres.
// ----------------------------------------------------------------------------
module lpc_scale #(
  parameter int RANGE_BITS = lpc_pkg::RANGE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [RANGE_BITS-1:0]               range_i,
  input  logic [1:0]                          quad_i,
  input  logic signed [lpc_pkg::CX_W-1:0]     x_i,
  input  logic signed [lpc_pkg::CX_W-1:0]     y_i,
  output logic                                valid_o,
  output logic signed [lpc_pkg::COORD_W-1:0]  point_x_o,
  output logic signed [lpc_pkg::COORD_W-1:0]  point_y_o
);
  import lpc_pkg::*;

  localparam int PROD_W = RANGE_BITS + TRIG_W + 1;

  logic signed [TRIG_W-1:0] c_rnd, s_rnd;
  logic signed [TRIG_W-1:0] cos_d, sin_d;
  logic                     valid_a_q;
  logic [RANGE_BITS-1:0]    range_a_q;
  logic signed [TRIG_W-1:0] cos_q, sin_q;
  logic                     valid_b_q;
  logic signed [PROD_W-1:0] px_q, py_q;

  // Round product to mm, half away from zero, saturate
  function automatic logic signed [COORD_W-1:0] coord_round(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0]  mag;
    logic [PROD_W-1:0]  rnd;
    logic [COORD_W-1:0] lim;
    mag = p[PROD_W-1] ? -p : p;
    rnd = (mag + PROD_W'(PROD_HALF)) >> PROD_ROUND_SH;
    if (rnd > PROD_W'(COORD_LIMIT)) begin
      lim = COORD_W'(COORD_LIMIT);
    end else begin
      lim = rnd[COORD_W-1:0];
    end
    return p[PROD_W-1] ? -$signed(lim) : $signed(lim);
  endfunction

  assign c_rnd = trig_round(x_i);
  assign s_rnd = trig_round(y_i);

  // Unfold the quadrant
  always_comb begin
    case (quad_e'(quad_i))
      QUAD_0: begin
        cos_d = c_rnd;
        sin_d = s_rnd;
      end
      QUAD_1: begin
        cos_d = -s_rnd;
        sin_d = c_rnd;
      end
      QUAD_2: begin
        cos_d = -c_rnd;
        sin_d = -s_rnd;
      end
      QUAD_3: begin
        cos_d = s_rnd;
        sin_d = -c_rnd;
      end
      default: begin
        cos_d = c_rnd;
        sin_d = s_rnd;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  // Trig register, then product register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      range_a_q <= range_i;
      cos_q     <= cos_d;
      sin_q     <= sin_d;
      px_q      <= $signed({1'b0, range_a_q}) * cos_q;
      py_q      <= $signed({1'b0, range_a_q}) * sin_q;
    end
  end

  assign valid_o   = valid_b_q;
  assign point_x_o = coord_round(px_q);
  assign point_y_o = coord_round(py_q);

endmodule

// File: rtl/lpc_out_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_out_skid
// Output register with a skid slot, so the pipeline stall is registered.
// ----------------------------------------------------------------------------
module lpc_out_skid (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic [lpc_pkg::OUT_TDATA_W-1:0]     data_i,
  output logic                                en_o,
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  output logic [lpc_pkg::OUT_TDATA_W-1:0]     m_tdata_o
);
  import lpc_pkg::*;

  logic                   push;
  logic                   out_v_q, out_v_d;
  logic                   skid_v_q, skid_v_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic [OUT_TDATA_W-1:0] skid_data_q, skid_data_d;

  // Pipeline advances while the skid slot is free
  assign en_o = ~skid_v_q;
  assign push = valid_i & en_o;

  always_comb begin
    out_v_d     = out_v_q;
    out_data_d  = out_data_q;
    skid_v_d    = skid_v_q;
    skid_data_d = skid_data_q;
    if (!out_v_q || m_tready_i) begin
      // Refill the output, oldest word first
      if (skid_v_q) begin
        out_v_d    = 1'b1;
        out_data_d = skid_data_q;
        skid_v_d   = 1'b0;
      end else begin
        out_v_d    = push;
        out_data_d = data_i;
      end
    end else if (push) begin
      // Output stalled: park the incoming word
      skid_v_d    = 1'b1;
      skid_data_d = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = out_data_q;

endmodule

// File: rtl/lpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_checker
// Port-level checks of the point stream and the input stall behavior.
// ----------------------------------------------------------------------------
module lpc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [lpc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import lpc_pkg::*;

  // A stalled input implies a word is waiting at the output
  a_stall_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no output word");

  // Draining the output frees the input next cycle
  a_stall_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready && m_axis_tready |=> s_axis_tready)
    else $error("input still stalled after output drained");

  // A refused word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // Coordinates saturate symmetrically and padding stays clear
  a_coord_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[16:0] != 17'h10000) &&
                      (m_axis_tdata[33:17] != 17'h10000) &&
                      (m_axis_tdata[OUT_TDATA_W-1:34] == '0))
    else $error("coordinate out of range or padding set");

endmodule

bind lidar_polar_to_cartesian lpc_checker u_lpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
